>>> design/slts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slts_pkg
// Shared constants and command/status types for the sparse triangular solver.
// ----------------------------------------------------------------------------
package slts_pkg;

    localparam int MAX_ROWS  = 1024;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int CNT_W     = 11;
    localparam int COL_W     = 10;
    localparam int DIV_STEPS = 64;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_COL  = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    typedef struct packed {
        logic accept;     // latch input beat, issue store read
        logic mac;        // add product into the partial sum
        logic div_start;  // load numerator and divisor
        logic div_step;   // one restoring step
        logic finish;     // form result, write store, advance row
        logic out_take;   // result beat taken downstream
    } slts_cmd_t;

    typedef struct packed {
        logic is_diag;
        logic div_done;
    } slts_sts_t;

endpackage

>>> design/sparse_lower_triangular_solve_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_lower_triangular_solve_unit
// Forward substitution L y = b over a CSR stream of Q16.16 nonzeros.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat per stored nonzero of a row,
// the diagonal beat last, carrying column, coefficient, rhs and diagonal.
// Output channel (out_valid/out_ready): one beat per diagonal beat, giving
// row, solution, status and final_row.
// Configuration channel (cfg_valid/cfg_ready): writes row_count; always ready.
// Off-diagonal beats pass through the solution store read and then the
// multiply-accumulate. A diagonal beat passes through the store read, the
// divider load and the 64-step restoring divider, one quotient bit per
// cycle, before its result is registered; the next beat may then be taken.
// One beat is in work at a time. A waiting result sits in the output
// register, so off-diagonal beats carry on under a stalled receiver; only a
// diagonal beat whose quotient is ready holds until that result is taken.
// Reset clears the row counter, partial sum and row status; row_count goes
// to 1024. The solution store has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module sparse_lower_triangular_solve_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [9:0]                 column,
    input  logic signed [31:0]         coefficient,
    input  logic signed [31:0]         rhs,
    input  logic                       diagonal,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [9:0]                 row,
    output logic signed [31:0]         solution,
    output logic [1:0]                 status,
    output logic                       final_row,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [10:0]                cfg_data
);

    slts_pkg::slts_cmd_t cmd;
    slts_pkg::slts_sts_t sts;
    logic [slts_pkg::CNT_W-1:0] row_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_count_reg <= slts_pkg::CNT_W'(slts_pkg::MAX_ROWS);
        else if (cfg_valid && cfg_ready)
            row_count_reg <= cfg_data;
    end

    slts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    slts_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .row_count   (row_count_reg),
        .column      (column),
        .coefficient (coefficient),
        .rhs         (rhs),
        .diagonal    (diagonal),
        .row         (row),
        .solution    (solution),
        .status      (status),
        .final_row   (final_row)
    );

endmodule

>>> design/slts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slts_ctrl
// Sequencer: accept a beat, multiply-accumulate or run the divider, emit.
// ----------------------------------------------------------------------------
module slts_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    input  slts_pkg::slts_sts_t sts,
    output slts_pkg::slts_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAC  = 4'b0010,
        S_DIV0 = 4'b0100,
        S_DIV  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            cmd.out_take   = 1'b1;
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                // store read data is now valid
                if (sts.is_diag)
                begin
                    state_next = S_DIV0;
                end
                else
                begin
                    cmd.mac    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV0:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    // hold the quotient until the result register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        cmd.finish     = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/slts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slts_datapath
// Solution store, saturating accumulator, restoring divider and result regs.
// ----------------------------------------------------------------------------
module slts_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  slts_pkg::slts_cmd_t                 cmd,
    output slts_pkg::slts_sts_t                 sts,
    input  logic [slts_pkg::CNT_W-1:0]          row_count,
    input  logic [slts_pkg::COL_W-1:0]          column,
    input  logic signed [31:0]                  coefficient,
    input  logic signed [31:0]                  rhs,
    input  logic                                diagonal,
    output logic [slts_pkg::COL_W-1:0]          row,
    output logic signed [31:0]                  solution,
    output logic [1:0]                          status,
    output logic                                final_row
);

    logic signed [31:0] store_mem [slts_pkg::MAX_ROWS];
    logic signed [31:0] rd_reg;

    logic signed [31:0]         coef_reg;
    logic signed [31:0]         rhs_reg;
    logic                       diag_reg;
    logic                       col_bad_reg;

    logic signed [63:0]         sum_reg;
    logic [slts_pkg::ROW_W-1:0] cur_reg;
    logic [1:0]                 err_reg;

    logic [63:0]                 rem_reg;
    logic [63:0]                 quo_reg;
    logic [31:0]                 dvs_reg;
    logic                        neg_reg;
    logic                        nsat_reg;
    logic [slts_pkg::STEP_W-1:0] step_reg;

    logic [slts_pkg::COL_W-1:0] row_reg;
    logic signed [31:0]         sol_reg;
    logic [1:0]                 status_reg;
    logic                       final_reg;

    logic signed [63:0] prod;
    logic signed [64:0] acc_wide;
    logic signed [63:0] acc_sat;
    logic               acc_ovf;
    logic signed [64:0] num_diff;
    logic signed [63:0] num_sat;
    logic               num_ovf;
    logic [64:0]        rem_shift;
    logic [64:0]        rem_try;
    logic signed [31:0] y_val;
    logic               q_ovf;
    logic [1:0]         fin_status;
    logic [slts_pkg::CNT_W-1:0] eff_rows;
    logic               last_row;

    // multiply from registered operands straight into the saturating add
    assign prod     = coef_reg * rd_reg;
    assign acc_wide = {sum_reg[63], sum_reg} + {prod[63], prod};
    assign acc_ovf  = acc_wide[64] != acc_wide[63];
    assign acc_sat  = acc_ovf ? (acc_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                              : acc_wide[63:0];

    // rhs * 2^16 minus the sum, in 65 bits
    assign num_diff = {{17{rhs_reg[31]}}, rhs_reg, 16'd0} - {sum_reg[63], sum_reg};
    assign num_ovf  = num_diff[64] != num_diff[63];
    assign num_sat  = num_ovf ? (num_diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                              : num_diff[63:0];

    assign rem_shift = {rem_reg, quo_reg[63]};
    assign rem_try   = rem_shift - {33'd0, dvs_reg};

    always_comb
    begin
        if (neg_reg)
        begin
            q_ovf = (quo_reg > 64'h8000_0000);
            y_val = q_ovf ? 32'sh8000_0000 : 32'(-quo_reg);
        end
        else
        begin
            q_ovf = (quo_reg > 64'h7FFF_FFFF);
            y_val = q_ovf ? 32'sh7FFF_FFFF : 32'(quo_reg);
        end
    end

    always_comb
    begin
        if (row_count == '0)
            eff_rows = slts_pkg::CNT_W'(1);
        else if (row_count > slts_pkg::CNT_W'(slts_pkg::MAX_ROWS))
            eff_rows = slts_pkg::CNT_W'(slts_pkg::MAX_ROWS);
        else
            eff_rows = row_count;
    end

    assign last_row = ({1'b0, cur_reg} + slts_pkg::CNT_W'(1)) >= eff_rows;

    always_comb
    begin
        if (coef_reg == '0)
            fin_status = slts_pkg::ST_ZERO;
        else if (err_reg != slts_pkg::ST_OK)
            fin_status = err_reg;
        else if (nsat_reg || q_ovf)
            fin_status = slts_pkg::ST_SAT;
        else
            fin_status = slts_pkg::ST_OK;
    end

    assign sts = '{is_diag:  diag_reg,
                   div_done: (step_reg == slts_pkg::STEP_W'(slts_pkg::DIV_STEPS))};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_reg <= store_mem[column];
        end
        if (cmd.finish)
        begin
            store_mem[cur_reg] <= (coef_reg == '0) ? 32'sd0 : y_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            coef_reg    <= coefficient;
            rhs_reg     <= rhs;
            diag_reg    <= diagonal;
            col_bad_reg <= column >= cur_reg;
        end
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            quo_reg  <= num_sat[63] ? 64'(-num_sat) : num_sat;
            dvs_reg  <= coef_reg[31] ? 32'(-coef_reg) : coef_reg;
            neg_reg  <= num_sat[63] != coef_reg[31];
            nsat_reg <= num_ovf;
        end
        else if (cmd.div_step)
        begin
            if (!rem_try[64])
            begin
                rem_reg <= rem_try[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            row_reg    <= cur_reg;
            sol_reg    <= (coef_reg == '0) ? 32'sd0 : y_val;
            status_reg <= fin_status;
            final_reg  <= last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            cur_reg  <= '0;
            err_reg  <= slts_pkg::ST_OK;
            step_reg <= '0;
        end
        else
        begin
            if (cmd.mac)
            begin
                if (col_bad_reg)
                begin
                    if (err_reg == slts_pkg::ST_OK)
                        err_reg <= slts_pkg::ST_COL;
                end
                else
                begin
                    sum_reg <= acc_sat;
                    if (acc_ovf && err_reg == slts_pkg::ST_OK)
                        err_reg <= slts_pkg::ST_SAT;
                end
            end
            if (cmd.div_start)
                step_reg <= '0;
            else if (cmd.div_step)
                step_reg <= step_reg + slts_pkg::STEP_W'(1);
            if (cmd.finish)
            begin
                sum_reg <= '0;
                err_reg <= slts_pkg::ST_OK;
                cur_reg <= last_row ? '0 : cur_reg + slts_pkg::ROW_W'(1);
            end
        end
    end

    assign row       = row_reg;
    assign solution  = sol_reg;
    assign status    = status_reg;
    assign final_row = final_reg;

endmodule

>>> test/sparse_lower_triangular_solve_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_lower_triangular_solve_unit_test
// Drives CSR rows of Q16.16 nonzeros into the forward-substitution unit, with
// random gaps on the input and random stalls on the output. A built-in solver
// tracks the solution store, the running sum and the row counter, and checks
// each solved row against the unit. Directed rows cover the fault statuses and
// saturation. Random phases run under several row_count settings.
// ----------------------------------------------------------------------------
module sparse_lower_triangular_solve_unit_test;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 100;

    typedef struct {
        logic [9:0]         col;
        logic signed [31:0] coef;
        logic signed [31:0] rhs;
        logic               diag;
    } nonzero_t;

    typedef struct {
        logic [9:0]         row;
        logic signed [31:0] sol;
        logic [1:0]         st;
        logic               fin;
    } solved_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [9:0]         column;
    logic signed [31:0] coefficient;
    logic signed [31:0] rhs;
    logic               diagonal;
    logic               out_valid;
    logic               out_ready;
    logic [9:0]         row;
    logic signed [31:0] solution;
    logic [1:0]         status;
    logic               final_row;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [10:0]        cfg_data;

    sparse_lower_triangular_solve_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .column      (column),
        .coefficient (coefficient),
        .rhs         (rhs),
        .diagonal    (diagonal),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row         (row),
        .solution    (solution),
        .status      (status),
        .final_row   (final_row),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // solver state
    logic signed [31:0] y_store [slts_pkg::MAX_ROWS];
    longint             run_sum;
    int                 solve_row;
    logic [1:0]         first_fault;
    logic [10:0]        rows_reg;

    nonzero_t pending_nz [$];
    solved_t  solved_q [$];
    int       errors;
    int       cycles;
    int       in_gap;
    int       out_gap;
    bit       calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (calm || r < 6)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint sum_sat(input longint a, input longint b, inout bit sat);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            sat = 1'b1;
            s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return s;
    endfunction

    function automatic longint diff_sat(input longint a, input longint b, inout bit sat);
        longint s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
        begin
            sat = 1'b1;
            s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return s;
    endfunction

    // Advance the solver by one nonzero; queue a solved row on a diagonal.
    task automatic solve_nonzero(input nonzero_t nz);
        int                 rows_eff;
        bit                 sat;
        longint             num;
        longint unsigned    mn;
        longint unsigned    md;
        longint unsigned    q;
        logic signed [31:0] y;
        solved_t            r;
        sat = 1'b0;
        y = '0;
        rows_eff = (rows_reg == 0) ? 1 :
                   (rows_reg > slts_pkg::MAX_ROWS ? slts_pkg::MAX_ROWS : rows_reg);
        if (!nz.diag)
        begin
            if (nz.col >= solve_row)
            begin
                if (first_fault == slts_pkg::ST_OK)
                    first_fault = slts_pkg::ST_COL;
            end
            else
            begin
                run_sum = sum_sat(run_sum, longint'(nz.coef) * longint'(y_store[nz.col]), sat);
                if (sat && first_fault == slts_pkg::ST_OK)
                    first_fault = slts_pkg::ST_SAT;
            end
            return;
        end
        if (nz.coef == 0)
            r.st = slts_pkg::ST_ZERO;
        else
        begin
            num = diff_sat(longint'(nz.rhs) * 65536, run_sum, sat);
            mn = num;
            if (num < 0)
                mn = -mn;
            md = longint'(nz.coef);
            if (nz.coef < 0)
                md = -md;
            q = mn / md;
            if ((num < 0) != (nz.coef < 0))
            begin
                if (q > 64'h8000_0000)
                begin
                    sat = 1'b1;
                    y = 32'sh8000_0000;
                end
                else
                    y = -q[31:0];
            end
            else
            begin
                if (q > 64'h7FFF_FFFF)
                begin
                    sat = 1'b1;
                    y = 32'sh7FFF_FFFF;
                end
                else
                    y = q[31:0];
            end
            r.st = (first_fault != slts_pkg::ST_OK) ? first_fault :
                   (sat ? slts_pkg::ST_SAT : slts_pkg::ST_OK);
        end
        y_store[solve_row] = y;
        r.row = solve_row[9:0];
        r.sol = y;
        r.fin = (solve_row + 1 >= rows_eff);
        solved_q.push_back(r);
        run_sum = 0;
        first_fault = slts_pkg::ST_OK;
        solve_row = (solve_row + 1 >= rows_eff) ? 0 : solve_row + 1;
    endtask

    task automatic send(input logic [9:0] col, input logic signed [31:0] coef,
                        input logic signed [31:0] b, input logic diag);
        nonzero_t nz;
        nz.col = col;
        nz.coef = coef;
        nz.rhs = b;
        nz.diag = diag;
        solve_nonzero(nz);
        pending_nz.push_back(nz);
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
        if (r < 8)
            return $urandom;
        if (r == 8)
            case ($urandom_range(0, 2))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                default: return 0;
            endcase
        return $urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000;
    endfunction

    function automatic logic signed [31:0] pick_pivot();
        int r;
        logic signed [31:0] v;
        r = $urandom_range(0, 14);
        if (r == 0)
            return 0;
        if (r == 1)
            return $urandom;
        v = $urandom_range(32'h8000, 32'h30000);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // One row: a few off-diagonals, mostly legal columns, then the diagonal.
    task automatic random_row();
        int n;
        logic [9:0] c;
        n = $urandom_range(0, 4);
        for (int k = 0; k < n; k++)
        begin
            if (solve_row > 0 && $urandom_range(0, 19) != 0)
                c = $urandom_range(0, solve_row - 1);
            else
                c = $urandom_range(0, 1023);
            send(c, pick_value(), $urandom, 1'b0);
        end
        send($urandom_range(0, 1023), pick_pivot(), pick_value(), 1'b1);
    endtask

    task automatic drain();
        while (pending_nz.size() != 0 || in_valid || solved_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_rows(input logic [10:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        rows_reg = v;
    endtask

    // input driver: hold a beat until taken, then idle or advance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_nz.size() != 0)
            begin
                in_valid    <= 1'b1;
                column      <= pending_nz[0].col;
                coefficient <= pending_nz[0].coef;
                rhs         <= pending_nz[0].rhs;
                diagonal    <= pending_nz[0].diag;
                void'(pending_nz.pop_front());
                in_gap <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor and output stalls
    always @(posedge clk or negedge rst_n)
    begin
        solved_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (solved_q.size() == 0)
                    report($sformatf("unexpected result for row %0d", row));
                else
                begin
                    e = solved_q.pop_front();
                    if (row !== e.row)
                        report($sformatf("row %0d, expected %0d", row, e.row));
                    if (solution !== e.sol)
                        report($sformatf("row %0d solution %h, expected %h",
                                         e.row, solution, e.sol));
                    if (status !== e.st)
                        report($sformatf("row %0d status %0d, expected %0d",
                                         e.row, status, e.st));
                    if (final_row !== e.fin)
                        report($sformatf("row %0d final_row %b, expected %b",
                                         e.row, final_row, e.fin));
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [10:0] settings [8];
        settings = '{11'd0, 11'd2047, 11'd1, 11'd5, 11'd1024, 11'd3, 11'd700, 11'd2};
        errors = 0;
        cycles = 0;
        calm = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        column = '0;
        coefficient = '0;
        rhs = '0;
        diagonal = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        run_sum = 0;
        solve_row = 0;
        first_fault = slts_pkg::ST_OK;
        rows_reg = 11'd1024;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // column not below the diagonal, plain diagonal
        send(10'd0, 32'sh0001_0000, 32'sh0, 1'b0);
        send(10'd0, 32'sh0001_0000, 32'sh7FFF_FFFF, 1'b1);
        // zero diagonal
        send(10'd5, 32'sh0, 32'sh0001_0000, 1'b1);
        // quotient saturation both ways; diagonal column ignored
        send(10'd1023, 32'sh1, 32'sh7FFF_FFFF, 1'b1);
        send(10'd1023, -32'sh1, 32'sh7FFF_FFFF, 1'b1);
        // sum saturation from extreme products
        send(10'd2, 32'sh7FFF_FFFF, 32'sh0, 1'b0);
        send(10'd2, 32'sh7FFF_FFFF, 32'sh0, 1'b0);
        send(10'd3, 32'sh8000_0000, 32'sh0, 1'b0);
        send(10'd0, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        // clean row
        send(10'd4, 32'sh0000_8000, 32'sh0, 1'b0);
        send(10'd1, 32'sh7FFF_FFFF, 32'sh0, 1'b0);
        send(10'd0, 32'sh0001_0000, -32'sh0001_0000, 1'b1);
        // bad column, then zero diagonal: zero diagonal wins
        send(10'd900, 32'sh0001_0000, 32'sh0, 1'b0);
        send(10'd0, 32'sh0, 32'sh0001_0000, 1'b1);
        // quotient saturation from rhs minus a large sum
        send(10'd2, 32'sh7FFF_FFFF, 32'sh0, 1'b0);
        send(10'd0, 32'sh0000_0002, 32'sh8000_0000, 1'b1);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            calm = (p % 3 == 0);
            write_rows(settings[p]);
            for (int n = 0; n < 27; n++)
                random_row();
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
design/slts_pkg.sv
design/slts_ctrl.sv
design/slts_datapath.sv
design/sparse_lower_triangular_solve_unit.sv
test/sparse_lower_triangular_solve_unit_test.sv
